// ----- src/ost_pkg.sv -----
// shared types, constants and microcode rom for the overlap suppression table
// no dependencies
`default_nettype none

package ost_pkg;

  localparam int OST_TABLE_DEPTH = 32;
  localparam int COORD_W         = 12;
  localparam int AREA_W          = 2 * COORD_W;
  localparam int SLOT_W          = 5;
  localparam int COUNT_W         = 6;

  typedef struct packed {
    logic [COORD_W-1:0] h;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } rect_t;

  typedef struct packed {
    logic [7:0]  dyn;
    logic [15:0] score;
    logic [3:0]  meth;
    logic [7:0]  step;
  } rank_t;

  typedef struct packed {
    rank_t rank;
    rect_t rect;
  } entry_t;

  // result action codes
  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_REPLACE = 2'd1,
    ACT_LOST    = 2'd2,
    ACT_FULL    = 2'd3
  } action_t;

  // sequencer step addresses
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_TAIL = 2'd2,
    ST_EMIT = 2'd3
  } step_t;

  // datapath operations selected by the control word
  typedef enum logic [1:0] {
    OP_WAIT_IN = 2'd0,
    OP_SCAN    = 2'd1,
    OP_TAIL    = 2'd2,
    OP_EMIT    = 2'd3
  } op_t;

  // control word: operation, fall-through step, jump target when the condition holds
  typedef struct packed {
    op_t   op;
    step_t next;
    step_t jump;
  } ctrl_word_t;

  // status fed back from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic scan_done;
    logic out_free;
  } status_t;

  // control handed from the sequencer to the datapath
  typedef struct packed {
    op_t op;
  } ctrl_t;

  // microcode rom
  function automatic ctrl_word_t ucode(input step_t s);
    ctrl_word_t cw;
    unique case (s)
      ST_IDLE: cw = '{op: OP_WAIT_IN, next: ST_IDLE, jump: ST_SCAN};
      ST_SCAN: cw = '{op: OP_SCAN,    next: ST_SCAN, jump: ST_TAIL};
      ST_TAIL: cw = '{op: OP_TAIL,    next: ST_EMIT, jump: ST_EMIT};
      ST_EMIT: cw = '{op: OP_EMIT,    next: ST_EMIT, jump: ST_IDLE};
      default: cw = '{op: OP_WAIT_IN, next: ST_IDLE, jump: ST_IDLE};
    endcase
    return cw;
  endfunction

  // half-open span intersection test, zero length never meets
  function automatic logic spans_meet(input logic [COORD_W-1:0] a0,
                                      input logic [COORD_W-1:0] alen,
                                      input logic [COORD_W-1:0] b0,
                                      input logic [COORD_W-1:0] blen);
    logic [COORD_W:0] lo;
    logic [COORD_W:0] ae;
    logic [COORD_W:0] be;
    logic [COORD_W:0] hi;
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    ae = {1'b0, a0} + {1'b0, alen};
    be = {1'b0, b0} + {1'b0, blen};
    hi = (ae < be) ? ae : be;
    return hi > lo;
  endfunction

endpackage

`default_nettype wire

// ----- src/ost_if.sv -----
// valid/ready channel interfaces for segment input and result output
// depends on ost_pkg
`default_nettype none

interface ost_in_if
  import ost_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               first_of_image;
  logic [COORD_W-1:0] rect_x;
  logic [COORD_W-1:0] rect_y;
  logic [COORD_W-1:0] rect_width;
  logic [COORD_W-1:0] rect_height;
  logic [7:0]         focus_step;
  logic [3:0]         seg_method;
  logic [15:0]        seg_score;
  logic [7:0]         dyn_range;

  modport source (output valid, first_of_image, rect_x, rect_y, rect_width, rect_height,
                  focus_step, seg_method, seg_score, dyn_range,
                  input ready);
  modport sink (input valid, first_of_image, rect_x, rect_y, rect_width, rect_height,
                focus_step, seg_method, seg_score, dyn_range,
                output ready);
endinterface

interface ost_out_if
  import ost_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] unique_count;

  modport source (output valid, action, slot, unique_count, input ready);
  modport sink (input valid, action, slot, unique_count, output ready);
endinterface

`default_nettype wire

// ----- src/ost_sequencer.sv -----
// microcoded sequencer: step register, control rom lookup, conditional jump
// depends on ost_pkg
`default_nettype none

module ost_sequencer
  import ost_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t status,
  output ctrl_t        ctrl
);

  step_t      step;
  step_t      step_next;
  ctrl_word_t cw;
  logic       cond;

  // step register
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // rom lookup and branch condition select
  always_comb begin
    cw = ucode(step);
    unique case (cw.op)
      OP_WAIT_IN: cond = status.in_valid;
      OP_SCAN:    cond = status.scan_done;
      OP_TAIL:    cond = 1'b1;
      OP_EMIT:    cond = status.out_free;
      default:    cond = 1'b0;
    endcase
    step_next = cond ? cw.jump : cw.next;
    ctrl.op   = cw.op;
  end

endmodule

`default_nettype wire

// ----- src/overlap_suppression_table_unit.sv -----
// overlap suppression table top level: table memory, scan datapath, output register
// depends on ost_pkg, ost_if (ost_in_if, ost_out_if), ost_sequencer
//
// usage:
//   in_ch carries one detected segment per beat (rectangle, step, method, score,
//   dynamic range, first_of_image). out_ch carries one result per segment: the
//   action taken, the table slot written or matched, and the unique count.
//   a segment is scanned against stored entries in order, one entry per cycle,
//   until the first overlap or the end of the filled part of the table.
// sequence:
//   each segment passes through the scan, tail and emit steps in that order. the
//   scan reads one table entry per cycle and stops at the first overlap; with no
//   overlap it ends with the end-of-table check. one segment is in work at a
//   time: the next is accepted only after the last one reaches the output register.
// reset:
//   rst empties the table (entry count zero), drops any pending result and holds
//   in_ch.ready low. table contents are not cleared; only entries below the count
//   are read.
// stall:
//   a result waits in the output register while out_ch.ready is low; one more
//   segment may be accepted and scanned, then it waits until the register frees.
`default_nettype none

module overlap_suppression_table_unit
  import ost_pkg::*;
#(
  parameter int TABLE_DEPTH = OST_TABLE_DEPTH
) (
  input wire logic clk,
  input wire logic rst,
  ost_in_if.sink   in_ch,
  ost_out_if.source out_ch
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // sequencer
  status_t status;
  ctrl_t   ctrl;

  ost_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // table memory
  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;
  logic   wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // current segment and scan state
  rect_t         cur_rect;
  rank_t         cur_rank;
  logic [AREA_W-1:0] cur_area;
  logic [CW-1:0] j;
  logic [CW-1:0] j_next;
  logic [CW-1:0] total;
  logic          found;
  action_t       act;
  logic [CW-1:0] slot_q;

  // output register
  logic               out_valid;
  action_t            out_action;
  logic [SLOT_W-1:0]  out_slot;
  logic [COUNT_W-1:0] out_count;

  logic accept;
  logic at_end;
  logic hit;
  logic wins;
  logic out_free;
  logic [AREA_W-1:0] old_area;

  assign in_ch.ready = (ctrl.op == OP_WAIT_IN) && !rst;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  // overlap and winner decision for the entry read this cycle
  always_comb begin
    at_end   = (j == total);
    hit      = !at_end
               && spans_meet(cur_rect.x, cur_rect.w, rd_data.rect.x, rd_data.rect.w)
               && spans_meet(cur_rect.y, cur_rect.h, rd_data.rect.y, rd_data.rect.h);
    old_area = {{COORD_W{1'b0}}, rd_data.rect.w} * {{COORD_W{1'b0}}, rd_data.rect.h};
    if (cur_rank.step == rd_data.rank.step) begin
      wins = cur_area > old_area;
    end else if (cur_rank.meth == rd_data.rank.meth) begin
      wins = cur_rank.score > rd_data.rank.score;
    end else begin
      wins = cur_rank.dyn > rd_data.rank.dyn;
    end
  end

  assign status.in_valid  = in_ch.valid;
  assign status.scan_done = at_end || hit;
  assign status.out_free  = out_free;

  // scan index and read address
  always_comb begin
    j_next = j;
    if (accept) begin
      j_next = '0;
    end else if (ctrl.op == OP_SCAN && !at_end && !hit) begin
      j_next = j + 1'b1;
    end
    rd_addr = j_next[AW-1:0];
  end

  // memory write select: replace on a winning hit, append at the tail
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j[AW-1:0];
    if (ctrl.op == OP_SCAN && hit && wins) begin
      wr_en = 1'b1;
    end else if (ctrl.op == OP_TAIL && !found && total != DEPTH_C) begin
      wr_en   = 1'b1;
      wr_addr = total[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{rank: cur_rank, rect: cur_rect};
    end
    rd_data <= mem[rd_addr];
  end

  // segment capture, precomputed area
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_rect <= '{h: in_ch.rect_height, w: in_ch.rect_width,
                    y: in_ch.rect_y, x: in_ch.rect_x};
      cur_rank <= '{dyn: in_ch.dyn_range, score: in_ch.seg_score,
                    meth: in_ch.seg_method, step: in_ch.focus_step};
      cur_area <= {{COORD_W{1'b0}}, in_ch.rect_width} * {{COORD_W{1'b0}}, in_ch.rect_height};
    end
  end

  // scan control and decision registers
  always_ff @(posedge clk) begin
    if (rst) begin
      j      <= '0;
      total  <= '0;
      found  <= 1'b0;
      act    <= ACT_APPEND;
      slot_q <= '0;
    end else begin
      j <= j_next;
      if (accept) begin
        found <= 1'b0;
        if (in_ch.first_of_image) begin
          total <= '0;
        end
      end else if (ctrl.op == OP_SCAN && hit) begin
        found  <= 1'b1;
        act    <= wins ? ACT_REPLACE : ACT_LOST;
        slot_q <= j;
      end else if (ctrl.op == OP_TAIL && !found) begin
        if (total != DEPTH_C) begin
          act    <= ACT_APPEND;
          slot_q <= total;
          total  <= total + 1'b1;
        end else begin
          act    <= ACT_FULL;
          slot_q <= '0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && out_free) begin
      out_action <= act;
      out_slot   <= SLOT_W'(slot_q);
      out_count  <= COUNT_W'(total);
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.action       = out_action;
  assign out_ch.slot         = out_slot;
  assign out_ch.unique_count = out_count;

endmodule

`default_nettype wire
